### hdl/tts_pkg.sv
// Shared types and constants for the template token substituter.
package tts_pkg;

  localparam int MAX_VALUE_LEN_DEF = 32;
  localparam int NUM_KEYS_DEF      = 26;

  localparam logic [7:0]  END_MARK       = 8'd255;
  localparam logic [7:0]  FIRST_KEY_CHAR = 8'd97;
  localparam logic [11:0] THRESH_RESET   = 12'd1459;
  localparam logic [7:0]  TOKEN_RESET    = 8'd36;
  localparam logic [12:0] LIMIT_MIN      = 13'd2;
  localparam logic [12:0] LIMIT_MAX      = 13'd4096;

  localparam logic CFG_FRAME_LIMIT = 1'b0;
  localparam logic CFG_TOKEN_CHAR  = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_START    = 2'd2,
    OP_TEMPLATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT,
    ST_SUB,
    ST_END,
    ST_CLOSE
  } tts_state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LIT,
    EMIT_SUB,
    EMIT_END,
    EMIT_CLOSE
  } emit_t;

  typedef struct packed {
    logic  accept;
    emit_t emit;
  } tts_cmd_t;

  typedef struct packed {
    logic op3_live;   // template byte that is not ignored
    logic pending;    // this byte is a key
    logic is_end;
    logic is_token;
    logic sub_go;     // valid key with a non-empty value
    logic close_now;
    logic close_inc;  // frame full after one more byte
    logic sub_last;
    logic out_free;
  } tts_status_t;

endpackage

### hdl/template_token_substituter_top.sv
// Value ops, frame start and token bytes are only accepted; a literal byte is accepted, then
// its result is sent. A key byte emits its N-char value one char per cycle from the value
// RAM read port while results are not stalled, then a close result when the frame fills.
// Result transfers wait while result_stall is high; one item is in work at a time.
// Reset: all values empty, frame and position counters zero, frame_limit 1460, token '$'.
// The value RAM contents are not cleared; only written characters are read.
module template_token_substituter_top #(
  parameter int MAX_VALUE_LEN = tts_pkg::MAX_VALUE_LEN_DEF,
  parameter int NUM_KEYS      = tts_pkg::NUM_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [4:0]  key_index,
  input  logic [7:0]  data_byte,
  input  logic [15:0] start_offset,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] source_pos,
  output logic        last
);
  import tts_pkg::*;

  tts_cmd_t    cmd;
  tts_status_t status;

  assign cfg_ready = 1'b1;

  tts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tts_dp #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN),
    .NUM_KEYS      (NUM_KEYS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .key_index    (key_index),
    .data_byte    (data_byte),
    .start_offset (start_offset),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .source_pos   (source_pos),
    .last         (last)
  );

endmodule

### hdl/tts_ram.sv
// Generic simple dual-port RAM with registered read.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/tts_ctrl.sv
// Controller state machine: sequences item accept and result transfers.
module tts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  tts_pkg::tts_status_t status,
  output tts_pkg::tts_cmd_t    cmd
);
  import tts_pkg::*;

  tts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.emit   = EMIT_NONE;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (status.op3_live) begin
            if (status.pending) begin
              if (status.sub_go) begin
                state_next = ST_SUB;
              end else if (status.close_now) begin
                state_next = ST_CLOSE;
              end
            end else if (status.is_end) begin
              state_next = ST_END;
            end else if (!status.is_token) begin
              state_next = ST_LIT;
            end
          end
        end
      end
      ST_LIT: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_LIT;
          state_next = status.close_inc ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_SUB: begin
        if (status.out_free) begin
          cmd.emit = EMIT_SUB;
          if (status.sub_last) begin
            state_next = status.close_inc ? ST_CLOSE : ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_END;
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.emit   = EMIT_CLOSE;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/tts_dp.sv
// Datapath: config registers, dictionary, frame counters and result register.
module tts_dp #(
  parameter int MAX_VALUE_LEN = tts_pkg::MAX_VALUE_LEN_DEF,
  parameter int NUM_KEYS      = tts_pkg::NUM_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tts_pkg::tts_cmd_t    cmd,
  output tts_pkg::tts_status_t status,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [12:0]          cfg_data,
  input  logic [1:0]           op,
  input  logic [4:0]           key_index,
  input  logic [7:0]           data_byte,
  input  logic [15:0]          start_offset,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [1:0]           kind,
  output logic [7:0]           out_byte,
  output logic [15:0]          source_pos,
  output logic                 last
);
  import tts_pkg::*;

  localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int IW    = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;
  localparam int LW    = $clog2(MAX_VALUE_LEN + 1);
  localparam int DEPTH = NUM_KEYS * (2 ** IW);
  localparam int AW    = $clog2(DEPTH);

  logic [11:0]   thresh;
  logic [7:0]    token_char;
  logic [LW-1:0] value_len [NUM_KEYS];
  logic [12:0]   frame_count;
  logic [15:0]   src_pos;
  logic          pending;
  logic          done;

  logic [7:0]    lit_byte;
  logic [KW-1:0] sub_key;
  logic [LW-1:0] sub_len;
  logic [LW-1:0] sub_idx;

  logic [11:0]   thresh_next;
  logic          key_ok;
  logic [KW-1:0] key_sel;
  logic [LW-1:0] key_len;
  logic          append_ok;
  logic [7:0]    byte_off;
  logic          byte_key_ok;
  logic [KW-1:0] byte_key;
  logic [LW-1:0] byte_len;
  logic [LW:0]   idx_inc;
  logic [LW-1:0] idx_rd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [13:0]   fc_inc;

  // threshold is frame_limit minus one, with frame_limit clamped to 2..4096
  always_comb begin
    if (cfg_data < LIMIT_MIN) begin
      thresh_next = 12'd1;
    end else if (cfg_data > LIMIT_MAX) begin
      thresh_next = 12'd4095;
    end else begin
      thresh_next = 12'(cfg_data - 13'd1);
    end
  end

  assign key_ok    = ({27'd0, key_index} < NUM_KEYS);
  assign key_sel   = key_index[KW-1:0];
  assign key_len   = value_len[key_sel];
  assign append_ok = key_ok && (data_byte != 8'd0) && ({{(32-LW){1'b0}}, key_len} < MAX_VALUE_LEN);

  assign byte_off    = data_byte - FIRST_KEY_CHAR;
  assign byte_key_ok = (data_byte >= FIRST_KEY_CHAR) && ({24'd0, byte_off} < NUM_KEYS);
  assign byte_key    = byte_off[KW-1:0];
  assign byte_len    = value_len[byte_key];

  assign idx_inc = {1'b0, sub_idx} + {{LW{1'b0}}, 1'b1};
  assign idx_rd  = (cmd.emit == EMIT_SUB) ? idx_inc[LW-1:0] : sub_idx;
  assign fc_inc  = {1'b0, frame_count} + 14'd1;

  assign wr_en   = cmd.accept && (op_t'(op) == OP_APPEND) && append_ok;
  assign wr_addr = AW'({key_sel, key_len[IW-1:0]});
  // on accept, prefetch the first character of the key's value
  assign rd_addr = cmd.accept ? AW'({byte_key, {IW{1'b0}}})
                              : AW'({sub_key, idx_rd[IW-1:0]});

  tts_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    status.op3_live  = (op_t'(op) == OP_TEMPLATE) && !done;
    status.pending   = pending;
    status.is_end    = (data_byte == END_MARK);
    status.is_token  = (data_byte == token_char);
    status.sub_go    = byte_key_ok && (byte_len != '0);
    status.close_now = (frame_count >= {1'b0, thresh});
    status.close_inc = (fc_inc >= {2'b00, thresh});
    status.sub_last  = (idx_inc == {1'b0, sub_len});
    status.out_free  = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh       <= THRESH_RESET;
      token_char   <= TOKEN_RESET;
      for (int i = 0; i < NUM_KEYS; i++) begin
        value_len[i] <= '0;
      end
      frame_count  <= '0;
      src_pos      <= '0;
      pending      <= 1'b0;
      done         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_FRAME_LIMIT) begin
          thresh <= thresh_next;
        end else begin
          token_char <= cfg_data[7:0];
        end
      end
      if (cmd.accept) begin
        unique case (op_t'(op))
          OP_CLEAR: begin
            if (key_ok) begin
              value_len[key_sel] <= '0;
            end
          end
          OP_APPEND: begin
            if (append_ok) begin
              value_len[key_sel] <= key_len + {{(LW-1){1'b0}}, 1'b1};
            end
          end
          OP_START: begin
            src_pos     <= start_offset;
            frame_count <= '0;
            pending     <= 1'b0;
            done        <= 1'b0;
          end
          OP_TEMPLATE: begin
            if (!done) begin
              if (pending) begin
                pending <= 1'b0;
                src_pos <= src_pos + 16'd1;
              end else if (data_byte == END_MARK) begin
                done <= 1'b1;
              end else if (data_byte == token_char) begin
                pending <= 1'b1;
                src_pos <= src_pos + 16'd1;
              end else begin
                src_pos <= src_pos + 16'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit == EMIT_LIT || cmd.emit == EMIT_SUB) begin
        frame_count <= fc_inc[12:0];
      end else if (cmd.emit == EMIT_CLOSE) begin
        frame_count <= '0;
      end
      if (cmd.emit != EMIT_NONE) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit_byte <= data_byte;
      sub_key  <= byte_key;
      sub_len  <= byte_len;
      sub_idx  <= '0;
    end else if (cmd.emit == EMIT_SUB) begin
      sub_idx <= idx_inc[LW-1:0];
    end
    case (cmd.emit)
      EMIT_LIT: begin
        kind       <= KIND_DATA;
        out_byte   <= lit_byte;
        source_pos <= '0;
        last       <= !status.close_inc;
      end
      EMIT_SUB: begin
        kind       <= KIND_DATA;
        out_byte   <= rd_data;
        source_pos <= '0;
        last       <= status.sub_last && !status.close_inc;
      end
      EMIT_END: begin
        kind       <= KIND_END;
        out_byte   <= '0;
        source_pos <= '0;
        last       <= 1'b1;
      end
      EMIT_CLOSE: begin
        kind       <= KIND_CLOSE;
        out_byte   <= '0;
        source_pos <= src_pos;
        last       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
